// ----- hdl/blr_pkg.sv -----
package blr_pkg;

  localparam int DIM_BITS       = 12;
  localparam int ADDR_BITS      = 24;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = 12'd1280;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 12'd720;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

endpackage

// ----- hdl/blr_setup.sv -----
module blr_setup #(
  parameter int COORD_BITS = 13
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         steep,
  output logic signed [COORD_BITS-1:0] major_first,
  output logic signed [COORD_BITS-1:0] major_last,
  output logic signed [COORD_BITS-1:0] minor_first,
  output logic                         minor_down,
  output logic        [COORD_BITS-1:0] span,
  output logic        [COORD_BITS:0]   inc
);
  localparam int D = COORD_BITS + 1;

  logic signed [D-1:0]          dx;
  logic signed [D-1:0]          dy;
  logic        [COORD_BITS-1:0] adx;
  logic        [COORD_BITS-1:0] ady;
  logic        [COORD_BITS-1:0] minor_abs;
  logic signed [COORD_BITS-1:0] mj0, mj1, mn0, mn1;
  logic                         flip;

  assign dx  = D'(start_x) - D'(end_x);
  assign dy  = D'(start_y) - D'(end_y);
  assign adx = dx[D-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign ady = dy[D-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

  assign steep = adx < ady;

  // swap axes for steep lines
  assign mj0 = steep ? start_y : start_x;
  assign mn0 = steep ? start_x : start_y;
  assign mj1 = steep ? end_y : end_x;
  assign mn1 = steep ? end_x : end_y;

  // order the endpoints so the major coordinate rises
  assign flip        = mj0 > mj1;
  assign major_first = flip ? mj1 : mj0;
  assign major_last  = flip ? mj0 : mj1;
  assign minor_first = flip ? mn1 : mn0;
  assign minor_down  = flip ? !(mn0 > mn1) : !(mn1 > mn0);

  assign span      = steep ? ady : adx;
  assign minor_abs = steep ? adx : ady;
  assign inc       = {minor_abs, 1'b0};
endmodule

// ----- hdl/bresenham_line_rasterizer_core.sv -----
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall   | kind, start_x, start_y, end_x, end_y, line_color
// out      | out_valid / out_stall | active, pixel_x, pixel_y, inside_res,
//          |                       | pixel_address, pixel_color, last
// cfg      | cfg_write             | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; a step beat shows its result in the cycle after it is taken
// line state and the output register load in the same cycle; the address multiply
// sits between the line state and the output register
// rst is synchronous and restores the frame size and drops any line in progress
// in_stall is raised only while a result waits in the output register and out_stall is high
module bresenham_line_rasterizer_core #(
  parameter int COORD_BITS = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic signed [COORD_BITS-1:0]       start_x,
  input  logic signed [COORD_BITS-1:0]       start_y,
  input  logic signed [COORD_BITS-1:0]       end_x,
  input  logic signed [COORD_BITS-1:0]       end_y,
  input  logic [blr_pkg::COLOR_BITS-1:0]     line_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               active,
  output logic signed [COORD_BITS-1:0]       pixel_x,
  output logic signed [COORD_BITS-1:0]       pixel_y,
  output logic                               inside_res,
  output logic [blr_pkg::ADDR_BITS-1:0]      pixel_address,
  output logic [blr_pkg::COLOR_BITS-1:0]     pixel_color,
  output logic                               last,
  input  logic                               cfg_write,
  input  logic [blr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [blr_pkg::DIM_BITS-1:0]       cfg_data
);
  import blr_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int E    = COORD_BITS + 3;
  localparam int CMPW = (C > DIM_BITS) ? C : DIM_BITS;
  localparam int AW   = (DIM_BITS + C > ADDR_BITS) ? DIM_BITS + C : ADDR_BITS;
  localparam logic [C-1:0] ONE = C'(1);

  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] frame_height;

  // line state
  logic                line_active;
  logic                steep_flag;
  logic signed [C-1:0] major_pos;
  logic signed [C-1:0] major_end;
  logic signed [C-1:0] minor_pos;
  logic                minor_dir_down;
  logic signed [E-1:0] error_acc;
  logic        [C:0]   error_inc;
  logic        [C-1:0] major_span;
  logic [COLOR_BITS-1:0] held_color;

  // setup results
  logic                s_steep;
  logic signed [C-1:0] s_major_first, s_major_last, s_minor_first;
  logic                s_minor_down;
  logic        [C-1:0] s_span;
  logic        [C:0]   s_inc;

  blr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .steep       (s_steep),
    .major_first (s_major_first),
    .major_last  (s_major_last),
    .minor_first (s_minor_first),
    .minor_down  (s_minor_down),
    .span        (s_span),
    .inc         (s_inc)
  );

  logic take, take_start, take_step;
  assign in_stall   = out_valid && out_stall;
  assign take       = in_valid && !in_stall;
  assign take_start = take && (kind == KIND_START);
  assign take_step  = take && (kind == KIND_STEP);

  // current pixel
  logic signed [C-1:0] px, py;
  logic        [C-1:0] pxu, pyu;
  logic                in_frame;
  logic                at_end;
  logic [AW-1:0]       addr_full;

  assign px       = steep_flag ? minor_pos : major_pos;
  assign py       = steep_flag ? major_pos : minor_pos;
  assign pxu      = px;
  assign pyu      = py;
  assign in_frame = !px[C-1] && (CMPW'(pxu) < CMPW'(frame_width)) &&
                    !py[C-1] && (CMPW'(pyu) < CMPW'(frame_height));
  assign at_end = major_pos >= major_end;
  assign addr_full = AW'(frame_width) * AW'(pyu) + AW'(pxu);

  // error update
  logic signed [E-1:0] inc_e, span_e, acc_sum, acc_next;
  logic                minor_move;
  logic signed [C-1:0] minor_next;

  assign inc_e      = signed'(E'(error_inc));
  assign span_e     = signed'(E'(major_span));
  assign acc_sum    = error_acc + inc_e;
  assign minor_move = acc_sum > span_e;
  assign acc_next   = minor_move ? acc_sum - (span_e <<< 1) : acc_sum;
  assign minor_next = !minor_move ? minor_pos :
                      minor_dir_down ? minor_pos - ONE : minor_pos + ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active    <= 1'b0;
      steep_flag     <= 1'b0;
      major_pos      <= '0;
      major_end      <= '0;
      minor_pos      <= '0;
      minor_dir_down <= 1'b0;
      error_acc      <= '0;
      error_inc      <= '0;
      major_span     <= '0;
      held_color     <= '0;
    end else if (take_start) begin
      line_active    <= 1'b1;
      steep_flag     <= s_steep;
      major_pos      <= s_major_first;
      major_end      <= s_major_last;
      minor_pos      <= s_minor_first;
      minor_dir_down <= s_minor_down;
      error_acc      <= '0;
      error_inc      <= s_inc;
      major_span     <= s_span;
      held_color     <= line_color;
    end else if (take_step && line_active) begin
      if (at_end) begin
        line_active <= 1'b0;
      end else begin
        error_acc <= acc_next;
        minor_pos <= minor_next;
        major_pos <= major_pos + ONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_step) begin
      if (line_active) begin
        active        <= 1'b1;
        pixel_x       <= px;
        pixel_y       <= py;
        inside_res    <= in_frame;
        pixel_address <= in_frame ? addr_full[ADDR_BITS-1:0] : '0;
        pixel_color   <= held_color;
        last          <= at_end;
      end else begin
        // no line: an empty beat
        active        <= 1'b0;
        pixel_x       <= '0;
        pixel_y       <= '0;
        inside_res    <= 1'b0;
        pixel_address <= '0;
        pixel_color   <= '0;
        last          <= 1'b0;
      end
    end
  end
endmodule

// ----- bench/bresenham_line_rasterizer_core_tb.sv -----
module bresenham_line_rasterizer_core_tb;
  import blr_pkg::*;

  localparam int CW             = 13;
  localparam int COORD_MIN      = -(1 << (CW - 1));
  localparam int COORD_MAX      = (1 << (CW - 1)) - 1;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SEGMENTS       = 8;
  localparam int SEGMENT_BEATS  = 200;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic                  active;
    coord_t                x;
    coord_t                y;
    logic                  in_frame;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  class pixel_scoreboard;
    int                    frame_w;
    int                    frame_h;
    bit                    line_on;
    bit                    steep;
    bit                    minor_down;
    int                    major_at;
    int                    major_stop;
    int                    minor_at;
    int                    err_acc;
    int                    err_step;
    int                    span;
    logic [COLOR_BITS-1:0] color;
    pixel_t                pixels_due[$];
    int                    errors;

    function new();
      frame_w    = int'(FRAME_WIDTH_RESET);
      frame_h    = int'(FRAME_HEIGHT_RESET);
      line_on    = 0;
      steep      = 0;
      minor_down = 0;
      major_at   = 0;
      major_stop = 0;
      minor_at   = 0;
      err_acc    = 0;
      err_step   = 0;
      span       = 0;
      color      = '0;
      errors     = 0;
    endfunction

    static function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        frame_w = int'(data);
      end else if (idx == REG_FRAME_HEIGHT) begin
        frame_h = int'(data);
      end
    endfunction

    function void note_input(kind_t k, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                             logic [COLOR_BITS-1:0] c);
      int     ax;
      int     ay;
      int     bx;
      int     by;
      int     t;
      int     px;
      int     py;
      pixel_t p;
      if (k == KIND_START) begin
        ax = int'(sx);
        ay = int'(sy);
        bx = int'(ex);
        by = int'(ey);
        steep = mag(ax - bx) < mag(ay - by);
        if (steep) begin
          t = ax; ax = ay; ay = t;
          t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
          t = ax; ax = bx; bx = t;
          t = ay; ay = by; by = t;
        end
        line_on    = 1;
        major_at   = ax;
        major_stop = bx;
        minor_at   = ay;
        minor_down = !(by > ay);
        span       = bx - ax;
        err_step   = 2 * mag(by - ay);
        err_acc    = 0;
        color      = c;
      end else begin
        p.active   = 0;
        p.x        = '0;
        p.y        = '0;
        p.in_frame = 0;
        p.addr     = '0;
        p.color    = '0;
        p.last     = 0;
        if (line_on) begin
          px = steep ? minor_at : major_at;
          py = steep ? major_at : minor_at;
          p.active   = 1;
          p.x        = px[CW-1:0];
          p.y        = py[CW-1:0];
          p.in_frame = px >= 0 && px < frame_w && py >= 0 && py < frame_h;
          if (p.in_frame) p.addr = ADDR_BITS'(frame_w * py + px);
          p.color = color;
          p.last  = major_at >= major_stop;
          if (p.last) begin
            line_on = 0;
          end else begin
            err_acc += err_step;
            if (err_acc > span) begin
              minor_at += minor_down ? -1 : 1;
              err_acc  -= 2 * span;
            end
            major_at += 1;
          end
        end
        pixels_due.push_back(p);
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("beat with nothing due: active=%0b x=%0d y=%0d",
                         got.active, got.x, got.y));
        return;
      end
      want = pixels_due.pop_front();
      if (got.active !== want.active)
        report($sformatf("active %0b, want %0b", got.active, want.active));
      if (got.x !== want.x)
        report($sformatf("pixel_x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("pixel_y %0d, want %0d", got.y, want.y));
      if (got.in_frame !== want.in_frame)
        report($sformatf("inside_res %0b, want %0b", got.in_frame, want.in_frame));
      if (got.addr !== want.addr)
        report($sformatf("pixel_address %0h, want %0h", got.addr, want.addr));
      if (got.color !== want.color)
        report($sformatf("pixel_color %0h, want %0h", got.color, want.color));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       kind;
  coord_t                     start_x;
  coord_t                     start_y;
  coord_t                     end_x;
  coord_t                     end_y;
  logic [COLOR_BITS-1:0]      line_color;
  logic                       out_valid;
  logic                       out_stall;
  logic                       active;
  coord_t                     pixel_x;
  coord_t                     pixel_y;
  logic                       inside_res;
  logic [ADDR_BITS-1:0]       pixel_address;
  logic [COLOR_BITS-1:0]      pixel_color;
  logic                       last;
  logic                       cfg_write;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [DIM_BITS-1:0]        cfg_data;

  pixel_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int beats_sent    = 0;
  int hold_at       = -1;
  bit hold_req      = 0;
  int quiet_cycles  = 0;

  bresenham_line_rasterizer_core #(.COORD_BITS(CW)) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .line_color    (line_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .active        (active),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .inside_res    (inside_res),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last          (last),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off once asked for
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1;
      end else begin
        out_stall = $urandom_range(99) < stall_pct;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    pixel_t got;
    if (!rst && out_valid && !out_stall) begin
      got.active   = active;
      got.x        = pixel_x;
      got.y        = pixel_y;
      got.in_frame = inside_res;
      got.addr     = pixel_address;
      got.color    = pixel_color;
      got.last     = last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int clamp_coord(int v);
    return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic int near_rail();
    return $urandom_range(1) ? COORD_MAX - int'($urandom_range(12))
                             : COORD_MIN + int'($urandom_range(12));
  endfunction

  task automatic send_beat(kind_t k, int sx, int sy, int ex, int ey,
                           logic [COLOR_BITS-1:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid   = 1;
    kind       = k;
    start_x    = coord_t'(sx);
    start_y    = coord_t'(sy);
    end_x      = coord_t'(ex);
    end_y      = coord_t'(ey);
    line_color = c;
    do @(posedge clk); while (in_stall);
    sb.note_input(k, start_x, start_y, end_x, end_y, c);
    beats_sent++;
    if (beats_sent == hold_at) hold_req = 1;
  endtask

  // endpoint fields carry junk on a step beat
  task automatic send_step();
    send_beat(KIND_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int data);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data  = data[DIM_BITS-1:0];
    @(negedge clk);
    cfg_write = 0;
    sb.set_reg(idx, data[DIM_BITS-1:0]);
  endtask

  task automatic run_lines(int n_beats, int hold_after);
    int stop_at;
    int mode;
    int ax;
    int ay;
    int bx;
    int by;
    int span;
    int steps;
    stop_at = beats_sent + n_beats;
    if (hold_after >= 0) hold_at = beats_sent + hold_after;
    while (beats_sent < stop_at) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        ax = int'($urandom_range(240)) - 40;
        ay = int'($urandom_range(240)) - 40;
        bx = ax + int'($urandom_range(60)) - 30;
        by = ay + int'($urandom_range(60)) - 30;
      end else if (mode < 85) begin
        ax = clamp_coord(int'($urandom_range(8191)) + COORD_MIN);
        ay = clamp_coord(int'($urandom_range(8191)) + COORD_MIN);
        bx = clamp_coord(int'($urandom_range(8191)) + COORD_MIN);
        by = clamp_coord(int'($urandom_range(8191)) + COORD_MIN);
      end else begin
        ax = near_rail();
        ay = $urandom_range(1) ? near_rail() : int'($urandom_range(200));
        bx = clamp_coord(ax + int'($urandom_range(20)) - 10);
        by = clamp_coord(ay + int'($urandom_range(20)) - 10);
      end
      span = pixel_scoreboard::mag(bx - ax);
      if (pixel_scoreboard::mag(by - ay) > span) span = pixel_scoreboard::mag(by - ay);
      // full walk plus up to two steps past the end; long lines, and some short ones, get cut short
      steps = span + 1 + $urandom_range(2);
      if (span > 64) steps = $urandom_range(1, 6);
      else if ($urandom_range(99) < 12) steps = $urandom_range(span);
      send_beat(KIND_START, ax, ay, bx, by, $urandom);
      repeat (steps) send_step();
    end
  endtask

  initial begin
    int seg_w[SEGMENTS];
    int seg_h[SEGMENTS];
    int s;
    seg_w = '{64, 4095, 1, 0, 150, 200, 4095, 0};
    seg_h = '{48, 4095, 1, 37, 0, 120, 1, 0};
    seg_w[5] = $urandom_range(1, 4095);
    rst        = 1;
    in_valid   = 0;
    kind       = KIND_STEP;
    start_x    = '0;
    start_y    = '0;
    end_x      = '0;
    end_y      = '0;
    line_color = '0;
    cfg_write  = 0;
    cfg_index  = REG_FRAME_WIDTH;
    cfg_data   = '0;
    repeat (9) @(negedge clk);
    rst = 0;

    // directed lines at the default frame size
    send_step();
    send_beat(KIND_START, 5, 5, 5, 5, 32'h0000_0000);
    send_step();
    send_step();
    send_beat(KIND_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    repeat (3) send_step();
    send_beat(KIND_START, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'hA5A5_5A5A);
    repeat (2) send_step();
    send_beat(KIND_START, 3, 6, 5, 2, 32'h1234_5678);
    repeat (5) send_step();
    send_beat(KIND_START, -2, -1, 1, 0, 32'h8000_0001);
    repeat (4) send_step();
    send_beat(KIND_START, 1279, 719, 1280, 720, 32'h7FFF_FFFE);
    repeat (2) send_step();

    for (s = 0; s < SEGMENTS; s++) begin
      drain();
      write_reg(REG_FRAME_WIDTH, seg_w[s]);
      write_reg(REG_FRAME_HEIGHT, seg_h[s]);
      case (s % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      run_lines(SEGMENT_BEATS, (s == 0) ? SEGMENT_BEATS / 2 : -1);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
